// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// ===== sv/fpp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpp_pkg
// Register indexes and fixed field widths of the perspective projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpp_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int COORD_W    = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_ROT_ROW0    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROT_ROW1    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROT_ROW2    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRANS_X     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRANS_Y     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRANS_Z     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_DIST = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

`default_nettype wire

// ===== sv/fixed_point_perspective_projection.sv =====
// ----------------------------------------------------------------------------
// fixed_point_perspective_projection
// Rotate, translate and perspective-project one point per beat.
// ----------------------------------------------------------------------------
//  channel  dir  beat fields (low bit up)
//  req_     in   tdata: world_x, world_y, world_z
//  rsp_     out  tuser: visible; tdata: screen_x, screen_y
//  csr_     in   wen, addr, wdata (one register write per cycle)
//
// One point enters per cycle while the result is not stalled; the bit-per-stage
// restoring divider has DIV_N = 52 - FRAC_BITS stages.
// Reset clears the stage valid bits and loads register reset values.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none

`include "assert_macros.svh"

module fixed_point_perspective_projection
   import fpp_pkg::*;
#(
   parameter int FRAC_BITS = 12,
   parameter int CENTER_X  = 160,
   parameter int CENTER_Y  = 120
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [47:0]            req_tdata,   // world_x, world_y, world_z
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [31:0]            rsp_tdata,   // screen_x, screen_y
   output logic                   rsp_tuser,   // visible
   input  wire                    csr_wen,
   input  wire  [CSR_ADDR_W-1:0]  csr_addr,
   input  wire  [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PROD_W = 2 * COORD_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int CAM_W  = SUM_W - FRAC_BITS + 1;
   localparam int NUM_W  = CAM_W + COORD_W + 1;
   localparam int DIV_N  = NUM_W;
   localparam int NSTG   = DIV_N + 5;
   localparam int OUT_W  = NUM_W + 2;

   // registers
   logic [CSR_DATA_W-1:0] rot_ff [3];
   coord_type             trans_ff [3];
   logic [COORD_W-1:0]    dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= CSR_DATA_W'(4096);
         rot_ff[1]   <= CSR_DATA_W'(4096) << 16;
         rot_ff[2]   <= CSR_DATA_W'(4096) << 32;
         trans_ff[0] <= '0;
         trans_ff[1] <= '0;
         trans_ff[2] <= '0;
         dist_ff     <= COORD_W'(256);
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_ROT_ROW0:    rot_ff[0]   <= csr_wdata;
            CSR_ROT_ROW1:    rot_ff[1]   <= csr_wdata;
            CSR_ROT_ROW2:    rot_ff[2]   <= csr_wdata;
            CSR_TRANS_X:     trans_ff[0] <= csr_wdata[COORD_W-1:0];
            CSR_TRANS_Y:     trans_ff[1] <= csr_wdata[COORD_W-1:0];
            CSR_TRANS_Z:     trans_ff[2] <= csr_wdata[COORD_W-1:0];
            CSR_SCREEN_DIST: dist_ff     <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NSTG-1:0] vld_ff;
   logic            adv;

   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
      end
   end

   // stage 1: nine coefficient products
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   coord_type                world [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         world[i] = req_tdata[COORD_W*i +: COORD_W];
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(rot_ff[r][COORD_W*c +: COORD_W]) * world[c];
         end
      end
   end

   // stage 2: row sums, scale down, translate
   logic signed [CAM_W-1:0] cam_ff [3];
   logic signed [CAM_W-1:0] cam_in [3];
   logic signed [SUM_W-1:0] row_sum [3];
   logic signed [SUM_W-1:0] row_shr [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                    + SUM_W'(prod_ff[r][2]);
         row_shr[r] = row_sum[r] >>> FRAC_BITS;
         cam_in[r]  = $signed(row_shr[r][CAM_W-1:0])
                    + {{(CAM_W-COORD_W){trans_ff[r][COORD_W-1]}}, trans_ff[r]};
      end
   end

   // stage 3: perspective scale and depth test
   logic signed [NUM_W-1:0] scl_ff [2];
   logic signed [NUM_W-1:0] scl_in [2];
   logic [CAM_W-1:0]        dz_ff;
   logic                    vis3_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         scl_in[i] = NUM_W'(cam_ff[i] * $signed({1'b0, dist_ff}));
      end
   end

   // divider stages: stage 0 holds magnitudes, stage k has k quotient bits
   logic [NUM_W-1:0] quo_ff [2][DIV_N+1];
   logic [CAM_W-1:0] rem_ff [2][DIV_N+1];
   logic [NUM_W-1:0] quo_in [2][DIV_N+1];
   logic [CAM_W-1:0] rem_in [2][DIV_N+1];
   logic             neg_ff [2][DIV_N+1];
   logic             vis_ff [DIV_N+1];
   logic [CAM_W-1:0] dsr_ff [DIV_N+1];
   logic [CAM_W:0]   trial [2][DIV_N+1];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         quo_in[i][0] = scl_ff[i][NUM_W-1] ? NUM_W'(-scl_ff[i]) : NUM_W'(scl_ff[i]);
         rem_in[i][0] = '0;
         trial[i][0]  = '0;
         for (int k = 1; k <= DIV_N; k++) begin
            trial[i][k] = {rem_ff[i][k-1], quo_ff[i][k-1][NUM_W-1]};
            if (trial[i][k] >= {1'b0, dsr_ff[k-1]}) begin
               rem_in[i][k] = CAM_W'(trial[i][k] - {1'b0, dsr_ff[k-1]});
               quo_in[i][k] = {quo_ff[i][k-1][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[i][k] = trial[i][k][CAM_W-1:0];
               quo_in[i][k] = {quo_ff[i][k-1][NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   // output stage: restore sign, recenter, saturate; hidden points give zero
   logic signed [OUT_W-1:0] scr [2];
   logic [COORD_W-1:0]      sat_in [2];
   logic [COORD_W-1:0]      sat_ff [2];
   logic                    vis_out_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         scr[i] = neg_ff[i][DIV_N] ? -$signed({2'b00, quo_ff[i][DIV_N]})
                                   : $signed({2'b00, quo_ff[i][DIV_N]});
         scr[i] = scr[i] + OUT_W'(i == 0 ? CENTER_X : CENTER_Y);
         priority if (!vis_ff[DIV_N]) begin
            sat_in[i] = '0;
         end else if (scr[i] > OUT_W'(32767)) begin
            sat_in[i] = 16'h7fff;
         end else if (scr[i] < -OUT_W'(32768)) begin
            sat_in[i] = 16'h8000;
         end else begin
            sat_in[i] = scr[i][COORD_W-1:0];
         end
      end
   end

   // payload registers, all advance together
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         cam_ff  <= cam_in;
         scl_ff  <= scl_in;
         dz_ff   <= cam_ff[2];
         vis3_ff <= cam_ff[2] > CAM_W'(1);
         for (int i = 0; i < 2; i++) begin
            neg_ff[i][0] <= scl_ff[i][NUM_W-1];
            for (int k = 0; k <= DIV_N; k++) begin
               quo_ff[i][k] <= quo_in[i][k];
               rem_ff[i][k] <= rem_in[i][k];
            end
            for (int k = 1; k <= DIV_N; k++) begin
               neg_ff[i][k] <= neg_ff[i][k-1];
            end
         end
         vis_ff[0] <= vis3_ff;
         dsr_ff[0] <= dz_ff;
         for (int k = 1; k <= DIV_N; k++) begin
            vis_ff[k] <= vis_ff[k-1];
            dsr_ff[k] <= dsr_ff[k-1];
         end
         sat_ff     <= sat_in;
         vis_out_ff <= vis_ff[DIV_N];
      end
   end

   assign rsp_tdata = {sat_ff[1], sat_ff[0]};
   assign rsp_tuser = vis_out_ff;

   `ASSERT_IMPLY(a_hidden_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `ASSERT_IMPLY(a_ready_rule, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))
   `ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, vld_ff[0])
   `ASSERT_NEXT(a_stall_hold, clock, reset, !adv, vld_ff == $past(vld_ff))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the perspective projection block: points stream in
// with random gaps, results are compared against an in-bench projection model
// across several matrix, offset and distance settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import fpp_pkg::*;

   localparam int LATENCY   = 52 - 12 + 5;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic      visible;
      coord_type scr_x;
      coord_type scr_y;
   } proj_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [47:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [31:0] rsp_tdata;
   wire         rsp_tuser;
   logic        csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fixed_point_perspective_projection u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_wen, .csr_addr, .csr_wdata
   );

   always #10 clock = ~clock;

   // bench copy of the registers
   logic [47:0]      m_row [3];
   logic signed [15:0] m_trans [3];
   logic [15:0]      m_dist;

   logic [47:0] point_q [$];
   proj_type    proj_q  [$];
   int          n_sent, n_recv, n_vis, n_sat, errors, idle_cycles;
   int          gap_in, gap_out;

   function automatic logic signed [63:0] sat_shift(logic [47:0] row,
                                                     logic [47:0] pt);
      logic signed [63:0] acc;
      acc = 0;
      for (int i = 0; i < 3; i++)
         acc += 64'(signed'(row[16*i +: 16])) * 64'(signed'(pt[16*i +: 16]));
      return acc >>> 12;
   endfunction

   function automatic coord_type clamp16(logic signed [63:0] v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic proj_type project_point(logic [47:0] pt);
      logic signed [63:0] c [3];
      logic signed [63:0] d;
      proj_type r;
      for (int i = 0; i < 3; i++) c[i] = sat_shift(m_row[i], pt) + m_trans[i];
      d = m_dist;
      r = '0;
      if (c[2] > 1) begin
         r.visible = 1'b1;
         r.scr_x = clamp16(160 + (c[0] * d) / c[2]);
         r.scr_y = clamp16(120 + (c[1] * d) / c[2]);
      end
      return r;
   endfunction

   // driver: present the next point once the gap has elapsed
   always @(negedge clock) begin
      if (!reset) begin
         if (gap_in > 0) begin
            gap_in--;
            req_tvalid <= 1'b0;
         end else if (point_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= point_q[0];
         end else
            req_tvalid <= 1'b0;
         if (gap_out > 0) begin
            gap_out--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: record accepted points and check results at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            proj_q.push_back(project_point(req_tdata));
            void'(point_q.pop_front());
            n_sent++;
            gap_in = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            proj_type got, want;
            idle_cycles = 0;
            got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]};
            n_recv++;
            if (got.visible) n_vis++;
            if (got.scr_x == 16'sh7fff || got.scr_x == 16'sh8000) n_sat++;
            if (proj_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat: %h", got);
            end else begin
               want = proj_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch beat %0d: exp vis=%b x=%0d y=%0d got vis=%b x=%0d y=%0d",
                        n_recv, want.visible, want.scr_x, want.scr_y,
                        got.visible, got.scr_x, got.scr_y);
               end
            end
            if ($urandom_range(0, 3) == 0) gap_out = $urandom_range(0, 16);
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [47:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ROT_ROW0:    m_row[0] = val;
         CSR_ROT_ROW1:    m_row[1] = val;
         CSR_ROT_ROW2:    m_row[2] = val;
         CSR_TRANS_X:     m_trans[0] = val[15:0];
         CSR_TRANS_Y:     m_trans[1] = val[15:0];
         CSR_TRANS_Z:     m_trans[2] = val[15:0];
         CSR_SCREEN_DIST: m_dist = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic drain();
      while (point_q.size() > 0 || proj_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 600)) - 16'd300;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rand_row(int diag);
      logic [47:0] r;
      for (int i = 0; i < 3; i++)
         case ($urandom_range(0, 3))
            0: r[16*i +: 16] = (i == diag) ? 16'd4096 : 16'd0;
            1: r[16*i +: 16] = 16'($urandom_range(0, 8192)) - 16'd4096;
            default: r[16*i +: 16] = 16'($urandom);
         endcase
      return r;
   endfunction

   task automatic random_points(int n);
      for (int i = 0; i < n; i++)
         point_q.push_back({rand_coord(), rand_coord(), rand_coord()});
   endtask

   initial begin
      m_row[0] = 48'd4096;
      m_row[1] = 48'd4096 << 16;
      m_row[2] = 48'd4096 << 32;
      m_trans = '{default: 0};
      m_dist = 16'd256;
      n_sent = 0; n_recv = 0; n_vis = 0; n_sat = 0; errors = 0;
      idle_cycles = 0; gap_in = 0; gap_out = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed under reset registers: extremes, behind camera, depth 1 and 2
      point_q.push_back({16'd1000, 16'd0, 16'd0});
      point_q.push_back({16'd1, 16'd0, 16'd0});
      point_q.push_back({16'd2, 16'd0, 16'd0});
      point_q.push_back({16'hffff, 16'd100, 16'd100});
      point_q.push_back({16'h7fff, 16'h7fff, 16'h7fff});
      point_q.push_back({16'h7fff, 16'h8000, 16'h8000});
      point_q.push_back({16'd2, 16'h7fff, 16'h8000});
      point_q.push_back({16'h8000, 16'h7fff, 16'h7fff});
      point_q.push_back({16'd300, 16'hff00, 16'd50});
      drain();

      // extreme registers; an out-of-range index must be ignored
      write_reg(CSR_ROT_ROW0, 48'hffff_ffff_ffff);
      write_reg(CSR_ROT_ROW1, 48'h8000_8000_8000);
      write_reg(CSR_ROT_ROW2, 48'h7fff_7fff_7fff);
      write_reg(CSR_TRANS_X, 48'h7fff);
      write_reg(CSR_TRANS_Y, 48'h8000);
      write_reg(CSR_TRANS_Z, 48'h7fff);
      write_reg(CSR_SCREEN_DIST, 48'hffff);
      write_reg(CSR_UNUSED, 48'h1234);
      point_q.push_back({16'h7fff, 16'h7fff, 16'h7fff});
      point_q.push_back({16'h8000, 16'h8000, 16'h8000});
      point_q.push_back({16'd0, 16'd0, 16'd0});
      point_q.push_back({16'h8000, 16'h7fff, 16'h0001});
      drain();
      write_reg(CSR_SCREEN_DIST, 48'd0);
      write_reg(CSR_TRANS_Z, 48'h8000);
      random_points(10);
      drain();

      // random settings; row coefficients mix unit, bounded and fully random values
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_ROT_ROW0, rand_row(0));
         write_reg(CSR_ROT_ROW1, rand_row(1));
         write_reg(CSR_ROT_ROW2, rand_row(2));
         write_reg(CSR_TRANS_X, 48'($urandom));
         write_reg(CSR_TRANS_Y, 48'($urandom));
         write_reg(CSR_TRANS_Z, $urandom_range(0, 1) ? 48'($urandom_range(0, 2000))
                                                    : 48'($urandom));
         write_reg(CSR_SCREEN_DIST, $urandom_range(0, 1) ? 48'($urandom_range(1, 512))
                                                        : 48'({$urandom, $urandom}));
         random_points(65);
         drain();
      end

      $display("covered %0d points, %0d visible, %0d with saturated x, 13 settings",
               n_recv, n_vis, n_sat);
      if (errors == 0 && proj_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
